// ===== src/assert_macros.svh =====
// assertion macros shared by the pixel fetch modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clk edge outside reset
`define PPF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PPF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ppf_pkg.sv =====
// types, constants and helper functions of the packed pixel fetch block
`timescale 1ns / 1ps
package ppf_pkg;

	localparam int DEF_STORE_BYTES     = 16384;
	localparam int DEF_PALETTE_ENTRIES = 16;
	localparam int QUEUE_DEPTH         = 4;

	localparam int CFG_IW  = 2;
	localparam int CFG_DW  = 15;
	localparam int BPP_W   = 6;
	localparam int DIM_W   = 14;
	localparam int SIZE_W  = 15;
	localparam int DIV_W   = 15;
	localparam int PROD_W  = 29;
	localparam int CALC_W  = 32;

	localparam logic [BPP_W-1:0] BPP_RESET = 6'd24;
	localparam logic [BPP_W-1:0] BPP_1     = 6'd1;
	localparam logic [BPP_W-1:0] BPP_2     = 6'd2;
	localparam logic [BPP_W-1:0] BPP_4     = 6'd4;
	localparam logic [BPP_W-1:0] BPP_8     = 6'd8;
	localparam logic [BPP_W-1:0] BPP_24    = 6'd24;

	typedef enum logic [1:0] {
		RQ_WBYTE = 2'd0,
		RQ_WPAL  = 2'd1,
		RQ_RAW   = 2'd2,
		RQ_COLOR = 2'd3
	} rq_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_UNSUP  = 2'd1,
		ST_RANGE  = 2'd2
	} st_t;

	typedef enum logic [1:0] {
		CFG_BPP    = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2,
		CFG_SIZE   = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		DEP_1,
		DEP_2,
		DEP_4,
		DEP_8,
		DEP_24,
		DEP_NONE
	} dep_t;

	typedef enum logic [1:0] {
		OP_WBYTE,
		OP_WPAL,
		OP_READ,
		OP_ERR
	} op_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_B0,
		BS_B1,
		BS_B2,
		BS_PAL
	} bst_t;

	typedef struct packed {
		rq_t               req_type;
		logic [13:0]       byte_address;
		logic [7:0]        byte_value;
		logic [3:0]        palette_index;
		logic [31:0]       palette_value;
		logic [13:0]       col_x;
		logic [13:0]       row_y;
	} req_t;

	typedef struct packed {
		logic [31:0] value;
		st_t         status;
	} res_t;

	// live image geometry seen by the front end
	typedef struct packed {
		logic [BPP_W-1:0]  bpp;
		logic [DIM_W-1:0]  width;
		logic [DIV_W-1:0]  stride;
	} geom_t;

	// classified work item, minus its store address
	typedef struct packed {
		op_t         op;
		st_t         status;
		logic        color;
		dep_t        dep;
		logic [2:0]  xpos;
		logic [7:0]  bval;
		logic [3:0]  pidx;
		logic [31:0] pval;
	} qctl_t;

	function automatic dep_t dep_of(input logic [BPP_W-1:0] bpp);
		dep_t d;
		d = DEP_NONE;
		if (bpp == BPP_1)
			d = DEP_1;
		else if (bpp == BPP_2)
			d = DEP_2;
		else if (bpp == BPP_4)
			d = DEP_4;
		else if (bpp == BPP_8)
			d = DEP_8;
		else if (bpp == BPP_24)
			d = DEP_24;
		return d;
	endfunction

	// msb-first pixel pick out of one store byte
	function automatic logic [7:0] px_extract(input logic [7:0] b, input dep_t d,
			input logic [2:0] xp);
		logic [7:0] r;
		r = '0;
		unique case (d)
			DEP_1:   r = (b >> ~xp) & 8'b00000001;
			DEP_2:   r = (b >> {~xp[1:0], 1'b0}) & 8'b00000011;
			DEP_4:   r = (b >> {~xp[0], 2'b00}) & 8'b00001111;
			DEP_8:   r = b;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/ppf_div.sv =====
// restoring divider for the row stride, one quotient bit per cycle
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ppf_div import ppf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SIZE_W-1:0]  dividend,
	input  logic [DIM_W-1:0]   divisor,
	output logic               busy,
	output logic [DIV_W-1:0]   quotient
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIM_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DIV_W-1:0] rem_sh;
	logic             fits;

	always_comb begin
		rem_sh = {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
		fits   = rem_sh >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			cnt_q <= CNT_W'(DIV_W);
			if (divisor == '0) begin
				// zero height gives a zero stride
				quo_q  <= '0;
				busy_q <= 1'b0;
			end else begin
				quo_q  <= dividend;
				busy_q <= 1'b1;
			end
		end else if (busy_q) begin
			rem_q  <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			quo_q  <= {quo_q[DIV_W-2:0], fits};
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= cnt_q != CNT_W'(1);
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

	`PPF_ASSERT_NEXT(a_div_starts, start && divisor != '0, busy_q, "divider did not start")

endmodule

// ===== src/ppf_fifo.sv =====
// small show-ahead queue between the front end and the back end
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ppf_fifo import ppf_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [W-1:0]               din,
	input  logic                       pop,
	output logic [W-1:0]               dout,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CW-1:0]    count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	assign dout  = mem_q[rd_q];
	assign empty = count_q == '0;
	assign count = count_q;

	`PPF_ASSERT_NOW(a_no_overflow, push && !pop, count_q < CW'(DEPTH), "queue overflow")
	`PPF_ASSERT_NOW(a_no_underflow, pop, count_q != '0, "queue underflow")

endmodule

// ===== src/ppf_front.sv =====
// front end: address arithmetic, range and depth checks, queue entry build
`timescale 1ns / 1ps
module ppf_front import ppf_pkg::*; #(
	parameter int STORE_BYTES = DEF_STORE_BYTES,
	parameter int AW          = $clog2(STORE_BYTES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  req_t          req,
	input  geom_t         geom,
	output logic          vld,
	output logic          push,
	output logic [AW-1:0] addr,
	output qctl_t         ctl
);

	localparam logic [CALC_W-1:0] LIMIT = CALC_W'(STORE_BYTES);

	dep_t              dep_in;
	logic [DIV_W-1:0]  factor;
	logic [PROD_W-1:0] prod_in;

	logic              vld_s1;
	req_t              req_s1;
	dep_t              dep_s1;
	logic [PROD_W-1:0] prod_s1;

	logic [CALC_W-1:0] sum;
	logic [CALC_W-1:0] base24;
	logic [CALC_W-1:0] last24;
	logic [CALC_W-1:0] addr_pk;
	logic [DIM_W-1:0]  xs;
	logic [CALC_W-1:0] waddr;

	// row term: y * width for 24-bit, y * stride for packed depths
	always_comb begin
		dep_in  = dep_of(geom.bpp);
		factor  = (dep_in == DEP_24) ? {1'b0, geom.width} : geom.stride;
		prod_in = {{(PROD_W-DIM_W){1'b0}}, req.row_y} * {{(PROD_W-DIV_W){1'b0}}, factor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req;
			dep_s1  <= dep_in;
			prod_s1 <= prod_in;
		end
	end

	always_comb begin
		unique case (dep_s1)
			DEP_1:   xs = req_s1.col_x >> 3;
			DEP_2:   xs = req_s1.col_x >> 2;
			DEP_4:   xs = req_s1.col_x >> 1;
			default: xs = req_s1.col_x;
		endcase
		sum     = CALC_W'(prod_s1) + CALC_W'(req_s1.col_x);
		base24  = sum + (sum << 1);
		last24  = base24 + CALC_W'(2);
		addr_pk = CALC_W'(prod_s1) + CALC_W'(xs);
		waddr   = CALC_W'(req_s1.byte_address);

		ctl.op     = OP_ERR;
		ctl.status = ST_OK;
		ctl.color  = req_s1.req_type == RQ_COLOR;
		ctl.dep    = dep_s1;
		ctl.xpos   = req_s1.col_x[2:0];
		ctl.bval   = req_s1.byte_value;
		ctl.pidx   = req_s1.palette_index;
		ctl.pval   = req_s1.palette_value;
		addr       = '0;

		unique case (req_s1.req_type)
			RQ_WBYTE: begin
				addr = waddr[AW-1:0];
				if (waddr < LIMIT)
					ctl.op = OP_WBYTE;
				else
					ctl.status = ST_RANGE;
			end
			RQ_WPAL: begin
				ctl.op = OP_WPAL;
			end
			RQ_RAW, RQ_COLOR: begin
				// depth check wins over the address check
				if (dep_s1 == DEP_NONE || (ctl.color && dep_s1 == DEP_8)) begin
					ctl.status = ST_UNSUP;
				end else if (dep_s1 == DEP_24) begin
					addr = base24[AW-1:0];
					if (last24 < LIMIT)
						ctl.op = OP_READ;
					else
						ctl.status = ST_RANGE;
				end else begin
					addr = addr_pk[AW-1:0];
					if (addr_pk < LIMIT)
						ctl.op = OP_READ;
					else
						ctl.status = ST_RANGE;
				end
			end
		endcase
	end

	assign push = vld_s1;
	assign vld  = vld_s1;

endmodule

// ===== src/ppf_back.sv =====
// back end: pixel store, palette and the read sequencer
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ppf_back import ppf_pkg::*; #(
	parameter int STORE_BYTES     = DEF_STORE_BYTES,
	parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
	parameter int AW              = $clog2(STORE_BYTES),
	parameter int PW              = $clog2(PALETTE_ENTRIES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  logic [AW-1:0] head_addr,
	input  qctl_t         head_ctl,
	output logic          pop,
	output logic          done,
	output res_t          result
);

	logic [7:0]  store_mem [STORE_BYTES];
	logic [31:0] pal_mem [PALETTE_ENTRIES];

	bst_t        state_q, state_d;
	qctl_t       cur_q;
	logic [AW-1:0] cur_addr_q;
	logic [AW-1:0] rd_addr;
	logic [7:0]  rd_data_q;
	logic [PW-1:0] pal_ra;
	logic [31:0] pal_rd_q;
	logic [7:0]  b_q, g_q;
	logic [7:0]  raw;
	logic        ld_cur, save_b, save_g, st_we, pal_we;
	logic        emit;
	res_t        emit_res;
	logic        done_q;
	res_t        result_q;

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		ld_cur   = 1'b0;
		save_b   = 1'b0;
		save_g   = 1'b0;
		st_we    = 1'b0;
		pal_we   = 1'b0;
		emit     = 1'b0;
		emit_res = '{value: '0, status: ST_OK};
		rd_addr  = cur_addr_q;
		pal_ra   = '0;
		raw      = px_extract(rd_data_q, cur_q.dep, cur_q.xpos);
		unique case (state_q)
			BS_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					unique case (head_ctl.op)
						OP_WBYTE: begin
							st_we = 1'b1;
							emit  = 1'b1;
						end
						OP_WPAL: begin
							pal_we = 1'b1;
							emit   = 1'b1;
						end
						OP_ERR: begin
							emit            = 1'b1;
							emit_res.status = head_ctl.status;
						end
						OP_READ: begin
							ld_cur  = 1'b1;
							rd_addr = head_addr;
							state_d = BS_B0;
						end
					endcase
				end
			end
			BS_B0: begin
				if (cur_q.dep == DEP_24) begin
					save_b  = 1'b1;
					rd_addr = cur_addr_q + 1'b1;
					state_d = BS_B1;
				end else if (cur_q.color) begin
					pal_ra  = PW'(raw[3:0]);
					state_d = BS_PAL;
				end else begin
					emit           = 1'b1;
					emit_res.value = 32'(raw);
					state_d        = BS_IDLE;
				end
			end
			BS_B1: begin
				save_g  = 1'b1;
				rd_addr = cur_addr_q + 1'b1;
				state_d = BS_B2;
			end
			BS_B2: begin
				emit           = 1'b1;
				emit_res.value = {8'h00, rd_data_q, g_q, b_q};
				state_d        = BS_IDLE;
			end
			BS_PAL: begin
				emit           = 1'b1;
				emit_res.value = pal_rd_q;
				state_d        = BS_IDLE;
			end
			default: state_d = BS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (st_we)
			store_mem[head_addr] <= head_ctl.bval;
		rd_data_q <= store_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pal_we)
			pal_mem[PW'(head_ctl.pidx)] <= head_ctl.pval;
		pal_rd_q <= pal_mem[pal_ra];
	end

	always_ff @(posedge clk) begin
		cur_addr_q <= rd_addr;
		result_q   <= emit_res;
		if (ld_cur)
			cur_q <= head_ctl;
		if (save_b)
			b_q <= rd_data_q;
		if (save_g)
			g_q <= rd_data_q;
	end

	assign done   = done_q;
	assign result = result_q;

	`PPF_ASSERT_NEXT(a_read_issue, state_q == BS_IDLE && pop && head_ctl.op == OP_READ,
		state_q == BS_B0, "read did not start its byte fetch")

endmodule

// ===== src/packed_pixel_fetch_palette.sv =====
// top level of the packed pixel fetch with palette lookup
`timescale 1ns / 1ps
//
// channel   direction  handshake                 payload
// -------   ---------  ------------------------  ---------------------------
// request   in         start & !busy             req    (req_t)
// result    out        done, one cycle, no stall  result (res_t)
// config    in         cfg_we                    cfg_index, cfg_data
//
// a request transfer reaches the queue after one front stage; the back end
//   then answers writes and errors from its idle state, packed or 8-bit raw
//   reads after one read of the single-read store, 24-bit reads after three
//   as it gives one byte per cycle, colour reads after a palette read too
// a write of image_height or image_size_bytes holds busy, but for a zero height,
//   while the row stride divider runs one quotient bit per cycle
// reset clears control state only; store and palette have no clearing pass
// busy also rises when the front stage and the queue together are full;
//   results are never held back by the receiver
//
module packed_pixel_fetch_palette import ppf_pkg::*; #(
	parameter int STORE_BYTES     = DEF_STORE_BYTES,
	parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	output logic              done,
	output res_t              result,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	localparam int AW  = $clog2(STORE_BYTES);
	localparam int PW  = $clog2(PALETTE_ENTRIES);
	localparam int QW  = AW + $bits(qctl_t);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	// configuration registers
	logic [BPP_W-1:0]  bpp_q;
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [SIZE_W-1:0] size_q;

	// stride divider
	logic              div_start;
	logic [SIZE_W-1:0] div_dividend;
	logic [DIM_W-1:0]  div_divisor;
	logic              div_busy;
	logic [DIV_W-1:0]  stride;

	// front end to queue
	logic              accept;
	geom_t             geom;
	logic              front_vld;
	logic              q_push;
	logic [AW-1:0]     f_addr;
	qctl_t             f_ctl;

	// queue to back end
	logic [QW-1:0]     q_dout;
	logic              q_empty;
	logic              q_pop;
	logic [QCW-1:0]    q_count;
	logic [QCW:0]      occupancy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q    <= BPP_RESET;
			width_q  <= '0;
			height_q <= '0;
			size_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BPP:    bpp_q    <= cfg_data[BPP_W-1:0];
				CFG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				CFG_SIZE:   size_q   <= cfg_data[SIZE_W-1:0];
			endcase
		end
	end

	// stride recompute starts on the write itself, with the new operand merged in
	always_comb begin
		div_start    = cfg_we && (cfg_idx_t'(cfg_index) == CFG_HEIGHT ||
			cfg_idx_t'(cfg_index) == CFG_SIZE);
		div_dividend = (cfg_idx_t'(cfg_index) == CFG_SIZE) ? cfg_data[SIZE_W-1:0] : size_q;
		div_divisor  = (cfg_idx_t'(cfg_index) == CFG_HEIGHT) ? cfg_data[DIM_W-1:0] : height_q;
	end

	ppf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (stride)
	);

	// one item may sit in the front stage, so it counts against queue room
	assign occupancy = {1'b0, q_count} + {{QCW{1'b0}}, front_vld};
	assign busy      = div_busy || (occupancy >= (QCW+1)'(QUEUE_DEPTH));
	assign accept    = start && !busy;

	assign geom = '{bpp: bpp_q, width: width_q, stride: stride};

	ppf_front #(
		.STORE_BYTES (STORE_BYTES),
		.AW          (AW)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.geom   (geom),
		.vld    (front_vld),
		.push   (q_push),
		.addr   (f_addr),
		.ctl    (f_ctl)
	);

	ppf_fifo #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    ({f_addr, f_ctl}),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty),
		.count  (q_count)
	);

	ppf_back #(
		.STORE_BYTES     (STORE_BYTES),
		.PALETTE_ENTRIES (PALETTE_ENTRIES),
		.AW              (AW),
		.PW              (PW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head_addr (q_dout[QW-1 -: AW]),
		.head_ctl  (qctl_t'(q_dout[$bits(qctl_t)-1:0])),
		.pop       (q_pop),
		.done      (done),
		.result    (result)
	);

endmodule

// ===== test/packed_pixel_fetch_palette_tb.sv =====
// self-checking testbench of the packed pixel fetch with palette lookup
`timescale 1ns / 1ps

module packed_pixel_fetch_palette_tb;
	import ppf_pkg::*;

	// cycles without any transfer before the run is declared hung
	localparam int WATCHDOG = 4000;
	// drain tail after the last expected result, covers the deepest read path
	localparam int TAIL = 16;
	localparam int PLAN_ITEMS = 40;
	// random items per sender idling phase
	localparam int PHASE_ITEMS = 13 * PLAN_ITEMS / 3;

	// shadow copy of the pixel store, palette and geometry, plus the
	// results that accepted requests still owe
	class pixel_fetch_shadow;
		logic [7:0]        store_mem [DEF_STORE_BYTES];
		bit                store_set [DEF_STORE_BYTES];
		logic [31:0]       colors [DEF_PALETTE_ENTRIES];
		bit                color_set [DEF_PALETTE_ENTRIES];
		logic [BPP_W-1:0]  bpp;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [SIZE_W-1:0] size_bytes;
		logic [DIV_W-1:0]  stride;
		res_t              due_results [$];
		int                faults;

		function new();
			bpp = BPP_RESET;
			width = '0;
			height = '0;
			size_bytes = '0;
			stride = '0;
			faults = 0;
		endfunction

		function void set_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] d);
			case (idx)
				CFG_BPP:    bpp = d[BPP_W-1:0];
				CFG_WIDTH:  width = d[DIM_W-1:0];
				CFG_HEIGHT: height = d[DIM_W-1:0];
				CFG_SIZE:   size_bytes = d[SIZE_W-1:0];
				default:    ;
			endcase
			stride = (height == 0) ? '0 : DIV_W'(size_bytes / height);
		endfunction

		// 0 for 24-bit and unsupported depths
		function int pack_factor();
			case (bpp)
				BPP_1:   return 8;
				BPP_2:   return 4;
				BPP_4:   return 2;
				BPP_8:   return 1;
				default: return 0;
			endcase
		endfunction

		function logic [7:0] byte_at(input int unsigned a);
			return store_set[a] ? store_mem[a] : 8'h00;
		endfunction

		// byte address and byte count of a pixel, or why there is none
		function st_t locate(input logic [13:0] x, input logic [13:0] y,
				output int unsigned base, output int nbytes);
			longint a;
			int ppb;
			base = 0;
			nbytes = 0;
			ppb = pack_factor();
			if (bpp == BPP_24) begin
				a = (longint'(y) * width + x) * 3;
				if (a + 2 >= DEF_STORE_BYTES)
					return ST_RANGE;
				base = a[31:0];
				nbytes = 3;
				return ST_OK;
			end
			if (ppb == 0)
				return ST_UNSUP;
			a = longint'(y) * stride + x / ppb;
			if (a >= DEF_STORE_BYTES)
				return ST_RANGE;
			base = a[31:0];
			nbytes = 1;
			return ST_OK;
		endfunction

		// raw pixel of an address that locate accepted
		function logic [23:0] fetch(input logic [13:0] x, input logic [13:0] y);
			int unsigned base;
			int nb;
			int ppb;
			int sh;
			void'(locate(x, y, base, nb));
			if (nb == 3)
				return {byte_at(base + 2), byte_at(base + 1), byte_at(base)};
			ppb = pack_factor();
			sh = int'(8 - ((x % ppb) + 1) * bpp);
			return 24'((byte_at(base) >> sh) & ((1 << bpp) - 1));
		endfunction

		function void take_request(input req_t r);
			res_t e;
			st_t st;
			int unsigned base;
			int nb;
			logic [23:0] raw;
			e.value = '0;
			e.status = ST_OK;
			case (r.req_type)
				RQ_WBYTE: begin
					if (r.byte_address < DEF_STORE_BYTES) begin
						store_mem[r.byte_address] = r.byte_value;
						store_set[r.byte_address] = 1'b1;
					end else
						e.status = ST_RANGE;
				end
				RQ_WPAL: begin
					colors[r.palette_index % DEF_PALETTE_ENTRIES] = r.palette_value;
					color_set[r.palette_index % DEF_PALETTE_ENTRIES] = 1'b1;
				end
				default: begin
					st = locate(r.col_x, r.row_y, base, nb);
					// colour at depth 8 is refused before the address matters
					if (r.req_type == RQ_COLOR && bpp == BPP_8)
						st = ST_UNSUP;
					e.status = st;
					if (st == ST_OK) begin
						raw = fetch(r.col_x, r.row_y);
						if (r.req_type == RQ_COLOR && bpp != BPP_24)
							e.value = color_set[raw[3:0]] ? colors[raw[3:0]] : '0;
						else
							e.value = {8'h00, raw};
					end
				end
			endcase
			due_results.push_back(e);
		endfunction

		function void match_result(input res_t got);
			res_t e;
			if (due_results.size() == 0) begin
				$error("unexpected result: value %h, status %0d", got.value, got.status);
				faults++;
				return;
			end
			e = due_results.pop_front();
			if (got.value !== e.value) begin
				$error("value: expected %h, actual %h", e.value, got.value);
				faults++;
			end
			if (got.status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, got.status);
				faults++;
			end
		endfunction
	endclass

	typedef struct {
		int bpp;
		int w;
		int h;
		int s;
	} setting_t;

	// geometry settings walked by the random part, extremes included
	setting_t plan [13] = '{
		'{1, 64, 128, 1024},
		'{2, 100, 50, 1250},
		'{4, 16383, 1, 16384},
		'{8, 0, 16383, 16384},
		'{24, 16383, 16383, 0},
		'{24, 37, 0, 16384},
		'{0, 5, 7, 99},
		'{32, 1, 16383, 16384},
		'{4, 1, 0, 0},
		'{1, 3, 3, 16384},
		'{63, 16383, 2, 3},
		'{2, 10, 16383, 1},
		'{24, 1, 1, 1}
	};

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	req_t              req;
	logic              done;
	res_t              result;
	logic              cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	pixel_fetch_shadow shadow;
	int                idle_pct;
	int                quiet;
	int                random_items;

	packed_pixel_fetch_palette uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// monitor: values read right after the edge are the ones the edge sampled
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				shadow.match_result(result);
			if ((start && !busy) || done)
				quiet = 0;
			else
				quiet = quiet + 1;
			if (quiet >= WATCHDOG) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// random payload with the wanted request kind, unused fields stay noisy
	function automatic req_t noise_req(input rq_t kind);
		req_t r;
		r.req_type = kind;
		r.byte_address = 14'($urandom);
		r.byte_value = 8'($urandom);
		r.palette_index = 4'($urandom);
		r.palette_value = $urandom;
		r.col_x = 14'($urandom);
		r.row_y = 14'($urandom);
		return r;
	endfunction

	// holds start until the transfer happens, with a random gap in front
	task automatic push_request(input req_t r);
		int gap;
		gap = 0;
		while (gap < 16 && $urandom_range(0, 99) < idle_pct)
			gap++;
		repeat (gap) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// busy still shows its pre-edge value here, so this edge took the transfer
		shadow.take_request(r);
	endtask

	task automatic write_byte(input logic [13:0] a, input logic [7:0] v);
		req_t r;
		r = noise_req(RQ_WBYTE);
		r.byte_address = a;
		r.byte_value = v;
		push_request(r);
	endtask

	task automatic write_color(input logic [3:0] i, input logic [31:0] v);
		req_t r;
		r = noise_req(RQ_WPAL);
		r.palette_index = i;
		r.palette_value = v;
		push_request(r);
	endtask

	// a read is preceded by writes of any store byte or palette entry
	// it would touch that holds nothing yet
	task automatic read_pixel(input rq_t kind, input logic [13:0] x, input logic [13:0] y);
		req_t r;
		st_t st;
		int unsigned base;
		int nb;
		logic [23:0] raw;
		st = shadow.locate(x, y, base, nb);
		if (st == ST_OK) begin
			for (int i = 0; i < nb; i++)
				if (!shadow.store_set[base + i])
					write_byte(14'(base + i), 8'($urandom));
			if (kind == RQ_COLOR && shadow.pack_factor() > 1) begin
				raw = shadow.fetch(x, y);
				if (!shadow.color_set[raw[3:0]])
					write_color(raw[3:0], $urandom);
			end
		end
		r = noise_req(kind);
		r.col_x = x;
		r.row_y = y;
		push_request(r);
	endtask

	// coordinates that mostly land inside the store at the current geometry
	function automatic void aim_inside(output logic [13:0] x, output logic [13:0] y);
		int unsigned ymax;
		int ppb;
		longint span;
		ppb = shadow.pack_factor();
		if (shadow.bpp == BPP_24) begin
			ymax = (shadow.width == 0) ? 16383 : 5460 / shadow.width;
			if (ymax > 16383)
				ymax = 16383;
			y = 14'($urandom_range(0, ymax));
			span = 5460 - longint'(y) * shadow.width;
			x = 14'($urandom_range(0, 32'((span > 16383) ? 16383 : span)));
		end else if (ppb == 0 || shadow.stride == 0) begin
			x = 14'($urandom);
			y = 14'($urandom);
		end else begin
			ymax = 16383 / shadow.stride;
			if (ymax > 16383)
				ymax = 16383;
			y = 14'($urandom_range(0, ymax));
			span = (16384 - longint'(y) * shadow.stride) * ppb - 1;
			x = 14'($urandom_range(0, 32'((span > 16383) ? 16383 : span)));
		end
	endfunction

	// wait until every owed result has arrived, then let the back end empty
	task automatic settle();
		start <= 1'b0;
		while (shadow.due_results.size() != 0)
			@(posedge clk);
		repeat (TAIL)
			@(posedge clk);
	endtask

	// register write only while idle; height and size writes start the
	// stride divider, so give busy a moment to rise and then wait it out
	task automatic write_reg(input cfg_idx_t idx, input int unsigned d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DW'(d);
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow.set_reg(idx, CFG_DW'(d));
		repeat (2)
			@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic apply_setting(input setting_t s);
		settle();
		write_reg(CFG_BPP, s.bpp);
		write_reg(CFG_WIDTH, s.w);
		write_reg(CFG_HEIGHT, s.h);
		write_reg(CFG_SIZE, s.s);
	endtask

	initial begin
		logic [13:0] x;
		logic [13:0] y;
		int pick;
		shadow = new();
		quiet = 0;
		idle_pct = 0;
		random_items = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_BPP;
		cfg_data <= '0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset geometry is 24-bit with width 0, so address is x*3
		write_byte(14'd0, 8'h00);
		write_byte(14'd1, 8'hFF);
		write_byte(14'd2, 8'h5A);
		write_byte(14'd16383, 8'hFF);
		write_color(4'd0, 32'h00000000);
		write_color(4'd15, 32'hFFFFFFFF);
		read_pixel(RQ_RAW, 14'd0, 14'd16383);
		// colour at 24-bit returns the raw triple
		read_pixel(RQ_COLOR, 14'd0, 14'd0);
		// last pixel whose third byte still fits, then the first that does not
		read_pixel(RQ_RAW, 14'd5460, 14'd0);
		read_pixel(RQ_RAW, 14'd5461, 14'd0);
		read_pixel(RQ_COLOR, 14'd16383, 14'd16383);

		// 8-bit: colour is refused, raw works with a zero stride
		settle();
		write_reg(CFG_BPP, BPP_8);
		read_pixel(RQ_COLOR, 14'd0, 14'd0);
		read_pixel(RQ_RAW, 14'd16383, 14'd9);

		// a depth outside the supported set refuses both read kinds
		settle();
		write_reg(CFG_BPP, 3);
		read_pixel(RQ_RAW, 14'd0, 14'd0);
		read_pixel(RQ_COLOR, 14'd16383, 14'd16383);

		// 1-bit, msb first, one row spanning the whole store
		apply_setting('{1, 16383, 1, 16384});
		read_pixel(RQ_COLOR, 14'd7, 14'd0);
		read_pixel(RQ_COLOR, 14'd8, 14'd0);
		read_pixel(RQ_RAW, 14'd0, 14'd1);
		read_pixel(RQ_RAW, 14'd16383, 14'd0);

		// random part: sender gaps at 20 percent, then 45, then none
		foreach (plan[p]) begin
			apply_setting(plan[p]);
			for (int k = 0; k < PLAN_ITEMS; k++) begin
				if (random_items < PHASE_ITEMS)
					idle_pct = 20;
				else if (random_items < 2 * PHASE_ITEMS)
					idle_pct = 45;
				else
					idle_pct = 0;
				pick = $urandom_range(0, 99);
				if (pick < 12)
					write_color(4'($urandom), $urandom);
				else if (pick < 30)
					write_byte(14'($urandom), 8'($urandom));
				else begin
					if ($urandom_range(0, 3) != 0)
						aim_inside(x, y);
					else begin
						x = 14'($urandom);
						y = 14'($urandom);
					end
					read_pixel($urandom_range(0, 1) ? RQ_COLOR : RQ_RAW, x, y);
				end
				random_items++;
			end
		end

		settle();
		if (shadow.faults == 0 && shadow.due_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/ppf_pkg.sv
src/ppf_div.sv
src/ppf_fifo.sv
src/ppf_front.sv
src/ppf_back.sv
src/packed_pixel_fetch_palette.sv
test/packed_pixel_fetch_palette_tb.sv
